// ===== hdl/itc_pkg.sv =====
// Shared constants, codes and types for the inode table refcount cache.
package itc_pkg;

  localparam int TABLE_SLOTS       = 64;
  localparam int SLOT_W            = $clog2(TABLE_SLOTS);
  localparam int SCAN_W            = $clog2(TABLE_SLOTS + 1);
  localparam int INODE_BYTES       = 32;
  localparam int SECTOR_BYTES      = 512;
  localparam int BOOT_SECTORS      = 2;
  localparam int INODES_PER_SECTOR = (SECTOR_BYTES / INODE_BYTES == 0) ? 1 :
                                     SECTOR_BYTES / INODE_BYTES;

  localparam int CMD_W    = 1;
  localparam int DEV_W    = 16;
  localparam int NUM_W    = 12;
  localparam int SLOTIN_W = 6;
  localparam int STAT_W   = 3;
  localparam int CNT_W    = 8;
  localparam int SEC_W    = 10;
  localparam int OFF_W    = 9;
  localparam int CFG_W    = 8;
  localparam int CFG_IDX_W = 1;

  localparam int IN_FIELDS_W  = DEV_W + NUM_W + SLOTIN_W;
  localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = STAT_W + SLOTIN_W + CNT_W + SEC_W + OFF_W;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef enum logic [CMD_W-1:0] {
    CMD_ACQUIRE = 1'b0,
    CMD_RELEASE = 1'b1
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_HIT       = 3'd0,
    ST_MISS      = 3'd1,
    ST_ZERO      = 3'd2,
    ST_FULL      = 3'd3,
    ST_RELEASED  = 3'd4,
    ST_SLOT_FREE = 3'd5,
    ST_SATURATED = 3'd6
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAP_SECTORS = 1'b0,
    CFG_SMAP_SECTORS = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [SLOT_W-1:0] rd_addr;
    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
    logic [CNT_W-1:0]  wr_cnt;
    logic              wr_tag;
    logic [DEV_W-1:0]  wr_dev;
    logic [NUM_W-1:0]  wr_num;
  } slot_req_t;

  typedef struct packed {
    logic [CNT_W-1:0] cnt;
    logic [DEV_W-1:0] dev;
    logic [NUM_W-1:0] num;
  } slot_rsp_t;

  typedef struct packed {
    status_t             status;
    logic [SLOTIN_W-1:0] slot_index;
    logic [CNT_W-1:0]    use_count;
    logic [SEC_W-1:0]    load_sector;
    logic [OFF_W-1:0]    load_offset;
  } res_t;

endpackage

// ===== hdl/itc_slot_mem.sv =====
// Slot table storage: count, device and inode memories with per-slot valid bits.
module itc_slot_mem (
  input  logic              clk,
  input  logic              rst_n,
  input  itc_pkg::slot_req_t req,
  output itc_pkg::slot_rsp_t rsp
);
  import itc_pkg::*;

  logic [CNT_W-1:0]       cnt_mem_r [TABLE_SLOTS];
  logic [DEV_W-1:0]       dev_mem_r [TABLE_SLOTS];
  logic [NUM_W-1:0]       num_mem_r [TABLE_SLOTS];
  logic [TABLE_SLOTS-1:0] valid_r;
  logic                   vld_q_r;
  logic [CNT_W-1:0]       cnt_q_r;
  logic [DEV_W-1:0]       dev_q_r;
  logic [NUM_W-1:0]       num_q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (req.wr_en) begin
      valid_r[req.wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      cnt_mem_r[req.wr_addr] <= req.wr_cnt;
    end
    if (req.wr_en && req.wr_tag) begin
      dev_mem_r[req.wr_addr] <= req.wr_dev;
      num_mem_r[req.wr_addr] <= req.wr_num;
    end
    vld_q_r <= valid_r[req.rd_addr];
    cnt_q_r <= cnt_mem_r[req.rd_addr];
    dev_q_r <= dev_mem_r[req.rd_addr];
    num_q_r <= num_mem_r[req.rd_addr];
  end

  assign rsp.cnt = vld_q_r ? cnt_q_r : '0;
  assign rsp.dev = dev_q_r;
  assign rsp.num = num_q_r;

endmodule

// ===== hdl/itc_ctrl.sv =====
// Sequencer: slot scan, compare and count update for acquire and release requests.
module itc_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [itc_pkg::CMD_W-1:0]     in_cmd,
  input  logic [itc_pkg::DEV_W-1:0]     in_dev,
  input  logic [itc_pkg::NUM_W-1:0]     in_num,
  input  logic [itc_pkg::SLOTIN_W-1:0]  in_slot,
  input  logic [itc_pkg::CFG_W-1:0]     imap,
  input  logic [itc_pkg::CFG_W-1:0]     smap,
  output itc_pkg::slot_req_t            req,
  input  itc_pkg::slot_rsp_t            rsp,
  output logic                          res_valid,
  input  logic                          res_ready,
  output itc_pkg::res_t                 res
);
  import itc_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_REL  = 5'b00010,
    S_SCAN = 5'b00100,
    S_DONE = 5'b01000,
    S_SPARE = 5'b10000
  } state_t;

  state_t              state_r, state_nxt;
  logic [DEV_W-1:0]    dev_r, dev_nxt;
  logic [NUM_W-1:0]    num_r, num_nxt;
  logic [SLOT_W-1:0]   slot_r, slot_nxt;
  logic [SCAN_W-1:0]   scan_r, scan_nxt;
  logic                pend_vld_r, pend_vld_nxt;
  logic [SLOT_W-1:0]   pend_idx_r, pend_idx_nxt;
  logic                have_free_r, have_free_nxt;
  logic [SLOT_W-1:0]   free_idx_r, free_idx_nxt;
  res_t                res_r, res_nxt;
  logic                scan_end;
  logic                tag_hit;
  logic [NUM_W-1:0]    rel;

  assign scan_end = (32'(scan_r) == TABLE_SLOTS);
  assign tag_hit  = (rsp.cnt != '0) && (rsp.dev == dev_r) && (rsp.num == num_r);
  assign rel      = num_r - NUM_W'(1);

  always_comb begin
    state_nxt     = state_r;
    dev_nxt       = dev_r;
    num_nxt       = num_r;
    slot_nxt      = slot_r;
    scan_nxt      = scan_r;
    pend_vld_nxt  = pend_vld_r;
    pend_idx_nxt  = pend_idx_r;
    have_free_nxt = have_free_r;
    free_idx_nxt  = free_idx_r;
    res_nxt       = res_r;
    req           = '0;
    req.rd_addr   = SLOT_W'(in_slot);
    req.wr_dev    = dev_r;
    req.wr_num    = num_r;
    in_tready     = (state_r == S_IDLE);
    res_valid     = (state_r == S_DONE);
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          dev_nxt  = in_dev;
          num_nxt  = in_num;
          slot_nxt = SLOT_W'(in_slot);
          res_nxt  = '0;
          if (cmd_t'(in_cmd) == CMD_RELEASE) begin
            if (32'(in_slot) >= TABLE_SLOTS) begin
              res_nxt.status     = ST_SLOT_FREE;
              res_nxt.slot_index = in_slot;
              state_nxt          = S_DONE;
            end else begin
              state_nxt = S_REL;
            end
          end else if (in_num == '0) begin
            res_nxt.status = ST_ZERO;
            state_nxt      = S_DONE;
          end else begin
            scan_nxt      = '0;
            pend_vld_nxt  = 1'b0;
            have_free_nxt = 1'b0;
            state_nxt     = S_SCAN;
          end
        end
      end
      S_REL: begin
        res_nxt.slot_index = SLOTIN_W'(slot_r);
        if (rsp.cnt == '0) begin
          res_nxt.status    = ST_SLOT_FREE;
          res_nxt.use_count = '0;
        end else begin
          req.wr_en         = 1'b1;
          req.wr_addr       = slot_r;
          req.wr_cnt        = rsp.cnt - CNT_W'(1);
          res_nxt.status    = ST_RELEASED;
          res_nxt.use_count = rsp.cnt - CNT_W'(1);
        end
        state_nxt = S_DONE;
      end
      S_SCAN: begin
        req.rd_addr = SLOT_W'(scan_r);
        if (!scan_end) begin
          pend_vld_nxt = 1'b1;
          pend_idx_nxt = SLOT_W'(scan_r);
          scan_nxt     = scan_r + SCAN_W'(1);
        end else begin
          pend_vld_nxt = 1'b0;
        end
        if (pend_vld_r) begin
          if (tag_hit) begin
            res_nxt.slot_index = SLOTIN_W'(pend_idx_r);
            if (rsp.cnt == CNT_MAX) begin
              res_nxt.status    = ST_SATURATED;
              res_nxt.use_count = CNT_MAX;
            end else begin
              req.wr_en         = 1'b1;
              req.wr_addr       = pend_idx_r;
              req.wr_cnt        = rsp.cnt + CNT_W'(1);
              res_nxt.status    = ST_HIT;
              res_nxt.use_count = rsp.cnt + CNT_W'(1);
            end
            state_nxt = S_DONE;
          end else if (rsp.cnt == '0 && !have_free_r) begin
            have_free_nxt = 1'b1;
            free_idx_nxt  = pend_idx_r;
          end
        end else if (scan_end) begin
          if (!have_free_r) begin
            res_nxt.status = ST_FULL;
          end else begin
            req.wr_en           = 1'b1;
            req.wr_addr         = free_idx_r;
            req.wr_cnt          = CNT_W'(1);
            req.wr_tag          = 1'b1;
            res_nxt.status      = ST_MISS;
            res_nxt.slot_index  = SLOTIN_W'(free_idx_r);
            res_nxt.use_count   = CNT_W'(1);
            res_nxt.load_sector = SEC_W'(BOOT_SECTORS) + SEC_W'(smap) + SEC_W'(imap)
                                + SEC_W'(rel / INODES_PER_SECTOR);
            res_nxt.load_offset = OFF_W'((rel % INODES_PER_SECTOR) * INODE_BYTES);
          end
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      pend_vld_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      pend_vld_r <= pend_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dev_r       <= dev_nxt;
    num_r       <= num_nxt;
    slot_r      <= slot_nxt;
    scan_r      <= scan_nxt;
    pend_idx_r  <= pend_idx_nxt;
    have_free_r <= have_free_nxt;
    free_idx_r  <= free_idx_nxt;
    res_r       <= res_nxt;
  end

  assign res = res_r;

endmodule

// ===== hdl/inode_table_refcount_cache.sv =====
// Top level of the inode table refcount cache: config registers, result register.
//
// Requests arrive on in_* (tuser = command, tdata = device, inode number,
// slot). An acquire scans the 64-slot table one slot per memory read and
// stops early at a hit; a miss or full table reads every slot. The result
// appears on out_* in the same cycle in which in_tready rises again.
// A release reads one slot.
// One request is worked at a time: in_tready is high only while the
// sequencer is idle.
// Results leave on out_* from an output register; the sequencer can accept
// the next request while a result waits there, and holds its own finished
// result until the output register frees up when the receiver stalls.
// Reset clears all slot valid bits (every slot free, no clearing pass) and
// sets both bitmap sector counts to 1. cfg_we writes register cfg_index;
// write only while idle.
module inode_table_refcount_cache (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [itc_pkg::IN_DATA_W-1:0]     in_tdata,   // device, inode_number, slot
  input  logic [itc_pkg::CMD_W-1:0]         in_tuser,   // command
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [itc_pkg::OUT_DATA_W-1:0]    out_tdata,  // status, slot_index, use_count,
                                                         // load_sector, load_offset
  input  logic                              cfg_we,
  input  logic [itc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [itc_pkg::CFG_W-1:0]         cfg_wdata
);
  import itc_pkg::*;

  logic [CFG_W-1:0] imap_r;
  logic [CFG_W-1:0] smap_r;
  slot_req_t        req;
  slot_rsp_t        rsp;
  logic             res_valid;
  logic             res_ready;
  res_t             res;
  logic             out_tvalid_r;
  res_t             out_res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      imap_r <= CFG_W'(1);
      smap_r <= CFG_W'(1);
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_IMAP_SECTORS: imap_r <= cfg_wdata;
        CFG_SMAP_SECTORS: smap_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  itc_slot_mem u_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  itc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_cmd    (in_tuser),
    .in_dev    (in_tdata[DEV_W-1:0]),
    .in_num    (in_tdata[DEV_W+NUM_W-1:DEV_W]),
    .in_slot   (in_tdata[IN_FIELDS_W-1:DEV_W+NUM_W]),
    .imap      (imap_r),
    .smap      (smap_r),
    .req       (req),
    .rsp       (rsp),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  assign res_ready = !out_tvalid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (res_ready) begin
      out_tvalid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {(OUT_DATA_W - OUT_FIELDS_W)'(0), out_res_r.load_offset,
                       out_res_r.load_sector, out_res_r.use_count,
                       out_res_r.slot_index, out_res_r.status};

  a_single_request: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request accepted while another is in progress");

  a_full_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_res_r.status == ST_FULL || out_res_r.status == ST_ZERO)
    |-> out_res_r.slot_index == '0 && out_res_r.use_count == '0)
    else $error("full or zero-inode result carries slot data");

  a_miss_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_res_r.status == ST_MISS |-> out_res_r.use_count == CNT_W'(1))
    else $error("newly claimed slot without count of one");

  a_load_only_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_res_r.status != ST_MISS
    |-> out_res_r.load_sector == '0 && out_res_r.load_offset == '0)
    else $error("load location given outside a miss");

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for inode_table_refcount_cache against a slot-table predictor.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import itc_pkg::*;

  localparam int ST_LO       = 0;
  localparam int IDX_LO      = ST_LO + STAT_W;
  localparam int CNT_LO      = IDX_LO + SLOTIN_W;
  localparam int SEC_LO      = CNT_LO + CNT_W;
  localparam int OFF_LO      = SEC_LO + SEC_W;
  localparam int DRAIN_CYCLES = TABLE_SLOTS + 16;
  localparam int STALL_LIMIT  = 2000;
  localparam int POOL_SIZE    = 20;

  class refcount_table_model;
    logic [CNT_W-1:0] use_cnt [TABLE_SLOTS];
    logic [DEV_W-1:0] dev_tag [TABLE_SLOTS];
    logic [NUM_W-1:0] num_tag [TABLE_SLOTS];
    logic [CFG_W-1:0] imap_sectors;
    logic [CFG_W-1:0] smap_sectors;
    res_t             pending_results [$];
    int               errors;
    int               status_seen [7];
    int               config_settings;

    function new();
      for (int i = 0; i < TABLE_SLOTS; i++) begin
        use_cnt[i] = '0;
      end
      imap_sectors = 8'd1;
      smap_sectors = 8'd1;
      errors     = 0;
      config_settings = 0;
      for (int i = 0; i < 7; i++) begin
        status_seen[i] = 0;
      end
    endfunction

    function void set_config(logic [CFG_W-1:0] imap, logic [CFG_W-1:0] smap);
      imap_sectors = imap;
      smap_sectors = smap;
      config_settings++;
    endfunction

    function void log_request(cmd_t cmd, logic [DEV_W-1:0] dev, logic [NUM_W-1:0] num,
                              logic [SLOTIN_W-1:0] slot);
      res_t r;
      int   free_slot;
      int   hit_slot;
      int   rel;
      r = '0;
      if (cmd == CMD_RELEASE) begin
        r.slot_index = slot;
        if (slot >= TABLE_SLOTS || use_cnt[slot] == 0) begin
          r.status = ST_SLOT_FREE;
        end else begin
          use_cnt[slot] = use_cnt[slot] - 1'b1;
          r.status    = ST_RELEASED;
          r.use_count = use_cnt[slot];
        end
      end else if (num == 0) begin
        r.status = ST_ZERO;
      end else begin
        free_slot = -1;
        hit_slot  = -1;
        for (int i = 0; i < TABLE_SLOTS; i++) begin
          if (use_cnt[i] != 0) begin
            if (hit_slot < 0 && dev_tag[i] == dev && num_tag[i] == num) hit_slot = i;
          end else if (free_slot < 0) begin
            free_slot = i;
          end
        end
        if (hit_slot >= 0) begin
          r.slot_index = SLOTIN_W'(hit_slot);
          if (use_cnt[hit_slot] == CNT_MAX) begin
            r.status    = ST_SATURATED;
            r.use_count = CNT_MAX;
          end else begin
            use_cnt[hit_slot] = use_cnt[hit_slot] + 1'b1;
            r.status    = ST_HIT;
            r.use_count = use_cnt[hit_slot];
          end
        end else if (free_slot < 0) begin
          r.status = ST_FULL;
        end else begin
          use_cnt[free_slot] = 8'd1;
          dev_tag[free_slot] = dev;
          num_tag[free_slot] = num;
          rel = int'(num) - 1;
          r.status      = ST_MISS;
          r.slot_index  = SLOTIN_W'(free_slot);
          r.use_count   = 8'd1;
          r.load_sector = SEC_W'(BOOT_SECTORS + int'(smap_sectors) + int'(imap_sectors)
                                 + rel / INODES_PER_SECTOR);
          r.load_offset = OFF_W'((rel % INODES_PER_SECTOR) * INODE_BYTES);
        end
      end
      status_seen[int'(r.status)]++;
      pending_results.push_back(r);
    endfunction

    function void compare_field(string name, int want, int got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [OUT_DATA_W-1:0] d);
      res_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing pending, expected none, actual %h", $time, d);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      compare_field("status", int'(want.status), int'(d[ST_LO +: STAT_W]));
      compare_field("slot_index", int'(want.slot_index), int'(d[IDX_LO +: SLOTIN_W]));
      compare_field("use_count", int'(want.use_count), int'(d[CNT_LO +: CNT_W]));
      compare_field("load_sector", int'(want.load_sector), int'(d[SEC_LO +: SEC_W]));
      compare_field("load_offset", int'(want.load_offset), int'(d[OFF_LO +: OFF_W]));
    endfunction

    function int busy_count();
      int n;
      n = 0;
      for (int i = 0; i < TABLE_SLOTS; i++) begin
        if (use_cnt[i] != 0) n++;
      end
      return n;
    endfunction

    function int pick_busy();
      int busy [$];
      for (int i = 0; i < TABLE_SLOTS; i++) begin
        if (use_cnt[i] != 0) busy.push_back(i);
      end
      if (busy.size() == 0) return -1;
      return busy[$urandom_range(0, busy.size() - 1)];
    endfunction
  endclass

  logic                    clk;
  logic                    rst_n;
  logic                    in_tvalid;
  logic                    in_tready;
  logic [IN_DATA_W-1:0]    in_tdata;   // device, inode_number, slot
  logic [CMD_W-1:0]        in_tuser;   // command
  logic                    out_tvalid;
  logic                    out_tready;
  logic [OUT_DATA_W-1:0]   out_tdata;  // status, slot_index, use_count, load_sector, load_offset
  logic                    cfg_we;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [CFG_W-1:0]        cfg_wdata;

  refcount_table_model tables;
  bit                  send_idle;
  bit                  recv_idle;
  int                  requests_sent;
  logic [DEV_W-1:0]    pool_dev [POOL_SIZE];
  logic [NUM_W-1:0]    pool_num [POOL_SIZE];

  inode_table_refcount_cache i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic send_request(cmd_t cmd, logic [DEV_W-1:0] dev, logic [NUM_W-1:0] num,
                              logic [SLOTIN_W-1:0] slot);
    int gap;
    gap = send_idle ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= IN_DATA_W'({slot, num, dev});
    do @(posedge clk); while (!in_tready);
    tables.log_request(cmd, dev, num, slot);
    requests_sent++;
  endtask

  task automatic acquire(logic [DEV_W-1:0] dev, logic [NUM_W-1:0] num);
    send_request(CMD_ACQUIRE, dev, num, SLOTIN_W'($urandom_range(0, 63)));
  endtask

  task automatic release_slot(int slot);
    send_request(CMD_RELEASE, DEV_W'($urandom), NUM_W'($urandom), SLOTIN_W'(slot));
  endtask

  task automatic write_config(logic [CFG_W-1:0] imap, logic [CFG_W-1:0] smap);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_IMAP_SECTORS;
    cfg_wdata <= imap;
    @(posedge clk);
    cfg_index <= CFG_SMAP_SECTORS;
    cfg_wdata <= smap;
    @(posedge clk);
    cfg_we <= 1'b0;
    tables.set_config(imap, smap);
  endtask

  // hold off new requests until every result is back and the block is idle
  task automatic settle();
    in_tvalid <= 1'b0;
    while (tables.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin : result_sink
    int stall;
    out_tready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = recv_idle ? $urandom_range(0, 4) : 0;
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      tables.check_result(out_tdata);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("%0t: no request or result moved for %0d cycles", $time, quiet);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int r;
    int s;
    int guard;
    int k;
    tables        = new();
    requests_sent = 0;
    send_idle     = 1'b0;
    recv_idle     = 1'b0;
    in_tvalid     <= 1'b0;
    in_tdata      <= '0;
    in_tuser      <= CMD_ACQUIRE;
    cfg_we        <= 1'b0;
    cfg_index     <= CFG_IMAP_SECTORS;
    cfg_wdata     <= '0;
    rst_n         <= 1'b0;
    pool_dev[0] = 16'hFFFF;
    pool_num[0] = 12'hFFF;
    pool_dev[1] = 16'h0000;
    pool_num[1] = 12'h001;
    for (int i = 2; i < POOL_SIZE; i++) begin
      pool_dev[i] = DEV_W'($urandom);
      pool_num[i] = NUM_W'($urandom_range(1, 4095));
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_config(8'd1, 8'd1);

    release_slot(0);
    release_slot(63);
    acquire(16'h0000, 12'h000);
    acquire(16'hFFFF, 12'h000);
    acquire(16'h0000, 12'h001);
    acquire(16'hFFFF, 12'hFFF);
    acquire(16'h0000, 12'h001);
    acquire(16'h0001, 12'h001);
    acquire(16'h0000, 12'h002);
    acquire(16'h0000, 12'd16);
    acquire(16'h0000, 12'd17);
    release_slot(0);
    release_slot(0);
    release_slot(0);
    acquire(16'hFFFF, 12'hFFF);
    send_request(CMD_ACQUIRE, 16'h0000, 12'h001, 6'h3F);
    send_request(CMD_RELEASE, 16'hFFFF, 12'hFFF, 6'd1);
    send_request(CMD_RELEASE, 16'h0000, 12'h000, 6'd1);
    acquire(16'h5555, 12'h800);
    acquire(16'hAAAA, 12'h555);
    release_slot(2);
    acquire(16'h0001, 12'h001);
    settle();

    // drive one slot into saturation, then step back below and up again
    send_idle = 1'b1;
    recv_idle = 1'b1;
    for (int i = 0; i < 257; i++) begin
      acquire(16'h1234, 12'hABC);
    end
    s = tables.pick_busy();
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      if (tables.use_cnt[i] == CNT_MAX) s = i;
    end
    release_slot(s);
    acquire(16'h1234, 12'hABC);
    acquire(16'h1234, 12'hABC);
    settle();

    write_config(8'd255, 8'd255);
    guard = 0;
    k = 0;
    while (tables.busy_count() < TABLE_SLOTS && guard < 200) begin
      acquire(DEV_W'(16'hC000 + k), NUM_W'($urandom_range(1, 4095)));
      k++;
      guard++;
    end
    for (int i = 0; i < 3; i++) begin
      acquire(DEV_W'(16'hD000 + i), NUM_W'($urandom_range(1, 4095)));
    end
    acquire(16'h1234, 12'hABC);
    acquire(16'hFFFF, 12'hFFF);
    s = tables.pick_busy();
    release_slot(s);
    if (tables.use_cnt[s] != 0) release_slot(s);
    acquire(16'hE000, 12'hFFF);
    acquire(16'hE001, 12'h001);
    settle();

    for (int i = 0; i < TABLE_SLOTS; i++) begin
      while (tables.use_cnt[i] != 0 && tables.use_cnt[i] < 8) release_slot(i);
    end
    settle();

    for (int chunk = 0; chunk < 7; chunk++) begin
      if (chunk == 0) write_config(8'd1, 8'd255);
      else if (chunk == 1) write_config(8'd255, 8'd1);
      else write_config(CFG_W'($urandom_range(1, 255)), CFG_W'($urandom_range(1, 255)));
      send_idle = ($urandom_range(0, 3) != 0);
      recv_idle = ($urandom_range(0, 3) != 0);
      for (int n = 0; n < 60; n++) begin
        r = $urandom_range(0, 99);
        if (r < 45) begin
          k = $urandom_range(0, POOL_SIZE - 1);
          acquire(pool_dev[k], pool_num[k]);
        end else if (r < 75) begin
          s = tables.pick_busy();
          if (s < 0) s = $urandom_range(0, 63);
          release_slot(s);
        end else if (r < 85) begin
          release_slot($urandom_range(0, 63));
        end else if (r < 95) begin
          acquire(DEV_W'($urandom), NUM_W'($urandom));
        end else begin
          acquire(DEV_W'($urandom), 12'h000);
        end
      end
      settle();
    end

    $display("Sent %0d requests over %0d register settings", requests_sent,
             tables.config_settings);
    $display("Hits %0d, misses %0d, zero inode %0d, full %0d, released %0d, %s %0d, %s %0d",
             tables.status_seen[ST_HIT], tables.status_seen[ST_MISS],
             tables.status_seen[ST_ZERO], tables.status_seen[ST_FULL],
             tables.status_seen[ST_RELEASED], "free slot", tables.status_seen[ST_SLOT_FREE],
             "saturated", tables.status_seen[ST_SATURATED]);
    if (tables.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
